@@ rtl/ple_pkg.sv @@
// Shared types and codes for the positional list engine.
`default_nettype none
package ple_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  // Widest values over the supported parameter range
  localparam int unsigned CNT_MAX_W  = 11;
  localparam int unsigned ELEM_MAX_W = 64;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 7;

  localparam logic [OPCODE_W-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_REAR  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REM_REAR  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_REM_AT    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [CNT_MAX_W-1:0]  idx;
    logic [CNT_MAX_W-1:0]  len;
    logic [ELEM_MAX_W-1:0] data;
  } ple_cmd_t;

endpackage
`default_nettype wire

@@ rtl/positional_list_engine.sv @@
// Top level of the positional list engine: control plus a chain of list cells.
//
// An ordered list of up to CAPACITY words, position 1 at the front.
// Command channel: opcode_i, position_i and value_i are taken at a rising
// edge with start_i high and busy_o low. busy_o stays low: the list is a
// row of cells, and at each clock edge every cell holds, loads the new word,
// or takes its left or right neighbor's word, so any insert or remove is
// done at the edge that takes the command.
// Result channel: one result per command, on status_o, removed_value_o and
// element_count_o, marked by done_o high for exactly one cycle, in the cycle
// after the command transfer. Throughput 1 command per cycle. The receiver
// cannot stall; each result stays until the next command's result replaces it.
// Failed commands (empty list, bad position, full list) report a status
// and leave the list unchanged. Opcodes 6 and 7 report ok and change nothing.
// Reset clears the length counter and done_o; cell contents need no reset,
// as only cells below the count are ever read.
`default_nettype none
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     done_o,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [VALUE_W-1:0]  removed_value_o,
  output logic      [COUNT_W-1:0]  element_count_o
);

  ple_cmd_t              cmd;
  logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
  logic [ELEM_WIDTH-1:0] left_w    [CAPACITY];
  logic [ELEM_WIDTH-1:0] right_w   [CAPACITY];
  logic [CAPACITY-1:0]   hit;
  logic [ELEM_WIDTH-1:0] rd_data;

  assign busy_o = 1'b0;

  ple_ctrl #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .rd_data_i       (rd_data),
    .cmd_o           (cmd),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .element_count_o (element_count_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w[i] = '0;
    end else begin : g_mid_r
      assign right_w[i] = cell_data[i+1];
    end

    ple_cell #(
      .CELL_IDX   (i),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .data_o  (cell_data[i]),
      .hit_o   (hit[i])
    );
  end

  // one-hot read of the cell being removed
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | (cell_data[i] & {ELEM_WIDTH{hit[i]}});
    end
  end

endmodule
`default_nettype wire

@@ rtl/ple_cell.sv @@
// One storage cell of the list chain: holds, shifts from a neighbor or loads.
`default_nettype none
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned CELL_IDX   = 0,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire ple_cmd_t              cmd_i,
  input  wire logic [ELEM_WIDTH-1:0] left_i,
  input  wire logic [ELEM_WIDTH-1:0] right_i,
  output logic      [ELEM_WIDTH-1:0] data_o,
  output logic                       hit_o
);

  localparam logic [CNT_MAX_W-1:0] MY_IDX = CNT_MAX_W'(CELL_IDX);
  localparam logic [CNT_MAX_W-1:0] MY_NXT = CNT_MAX_W'(CELL_IDX + 1);

  logic [ELEM_WIDTH-1:0] data_q, data_d;

  assign hit_o = (cmd_i.idx == MY_IDX);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (hit_o) begin
        data_d = cmd_i.data[ELEM_WIDTH-1:0];
      end else if (MY_IDX > cmd_i.idx && MY_IDX <= cmd_i.len) begin
        data_d = left_i;
      end
    end else if (cmd_i.rem) begin
      // close the gap: cells from the removed slot up to the one below the old tail pull down
      if (MY_IDX >= cmd_i.idx && MY_NXT < cmd_i.len) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

@@ rtl/ple_ctrl.sv @@
// Command decode, length counter and result registers of the list engine.
`default_nettype none
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic [VALUE_W-1:0]    value_i,
  input  wire logic [ELEM_WIDTH-1:0] rd_data_i,
  output ple_cmd_t                   cmd_o,
  output logic                       done_o,
  output logic      [STATUS_W-1:0]   status_o,
  output logic      [VALUE_W-1:0]    removed_value_o,
  output logic      [COUNT_W-1:0]    element_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned OW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [CW-1:0]       len_q, len_d;
  logic                done_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  removed_q, removed_d;
  logic [COUNT_W-1:0]  count_q;

  logic                  ins, rem, full, empty, bad_ins, bad_rem;
  logic [CW-1:0]         idx;
  logic [EW-1:0]         pos_ext, len_ext, pos_m1;
  logic [ELEM_MAX_W-1:0] rd_ext;
  logic [OW-1:0]         len_out;

  assign pos_ext = EW'(position_i);
  assign len_ext = EW'(len_q);
  assign pos_m1  = pos_ext - EW'(1);
  assign full    = (len_q == CAP);
  assign empty   = (len_q == '0);
  assign bad_ins = (pos_ext == '0) || (pos_ext > len_ext + EW'(1));
  assign bad_rem = (pos_ext == '0) || (pos_ext > len_ext);

  always_comb begin
    status_d = ST_OK;
    ins      = 1'b0;
    rem      = 1'b0;
    idx      = '0;
    unique case (opcode_i)
      OP_ADD_FRONT: begin
        if (full) status_d = ST_FULL;
        else      ins      = 1'b1;
      end
      OP_ADD_REAR: begin
        idx = len_q;
        if (full) status_d = ST_FULL;
        else      ins      = 1'b1;
      end
      OP_REM_FRONT: begin
        if (empty) status_d = ST_UNDERFLOW;
        else       rem      = 1'b1;
      end
      OP_REM_REAR: begin
        idx = len_q - CW'(1);
        if (empty) status_d = ST_UNDERFLOW;
        else       rem      = 1'b1;
      end
      OP_INS_AT: begin
        idx = pos_m1[CW-1:0];
        if (bad_ins)   status_d = ST_RANGE;
        else if (full) status_d = ST_FULL;
        else           ins      = 1'b1;
      end
      OP_REM_AT: begin
        idx = pos_m1[CW-1:0];
        if (bad_rem) status_d = ST_RANGE;
        else         rem      = 1'b1;
      end
      default: ;
    endcase
  end

  assign cmd_o.ins  = ins & start_i;
  assign cmd_o.rem  = rem & start_i;
  assign cmd_o.idx  = CNT_MAX_W'(idx);
  assign cmd_o.len  = CNT_MAX_W'(len_q);
  assign cmd_o.data = ELEM_MAX_W'(value_i);

  assign rd_ext    = ELEM_MAX_W'(rd_data_i);
  assign removed_d = rem ? rd_ext[VALUE_W-1:0] : '0;

  always_comb begin
    len_d = len_q;
    if (ins)      len_d = len_q + CW'(1);
    else if (rem) len_d = len_q - CW'(1);
  end

  assign len_out = OW'(len_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
      if (start_i) len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      count_q   <= len_out[COUNT_W-1:0];
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign element_count_o = count_q;

endmodule
`default_nettype wire

@@ verif/ple_checker.sv @@
// Result checker for the positional list engine: tracks the list and compares every result.
`timescale 1ns / 1ps
module ple_checker
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_i,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  input  wire logic                done_i,
  input  wire logic [STATUS_W-1:0] status_i,
  input  wire logic [VALUE_W-1:0]  removed_value_i,
  input  wire logic [COUNT_W-1:0]  element_count_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic [VALUE_W-1:0] list_words [$];
  list_result_t       expected_results [$];
  list_result_t       oldest;
  int                 fail_count;
  int                 pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Applies one command to the tracked list and returns the result it gives
  function automatic list_result_t apply_command(input logic [OPCODE_W-1:0] op,
                                                 input logic [POS_W-1:0]    pos,
                                                 input logic [VALUE_W-1:0]  val);
    list_result_t r;
    int len;
    int p;
    len       = list_words.size();
    p         = int'(pos);
    r.status  = ST_OK;
    r.removed = '0;
    case (op)
      OP_ADD_FRONT, OP_ADD_REAR: begin
        if (len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_ADD_FRONT) begin
          list_words.push_front(val);
        end else begin
          list_words.push_back(val);
        end
      end
      OP_REM_FRONT: begin
        if (len == 0) r.status = ST_UNDERFLOW;
        else r.removed = list_words.pop_front();
      end
      OP_REM_REAR: begin
        if (len == 0) r.status = ST_UNDERFLOW;
        else r.removed = list_words.pop_back();
      end
      OP_INS_AT: begin
        // range check wins over the full check
        if (p < 1 || p > len + 1) begin
          r.status = ST_RANGE;
        end else if (len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words.insert(p - 1, val);
        end
      end
      OP_REM_AT: begin
        if (p < 1 || p > len) begin
          r.status = ST_RANGE;
        end else begin
          r.removed = list_words[p - 1];
          list_words.delete(p - 1);
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_words.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_val,
                             input logic [VALUE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_words.delete();
      expected_results.delete();
      pending_count = 0;
    end else begin
      // result of the previous transfer is checked before the new one is queued
      if (done_i) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual status %0d removed %0h count %0d",
                   $time, status_i, removed_value_i, element_count_i);
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", VALUE_W'(oldest.status), VALUE_W'(status_i));
          check_field("removed_value", oldest.removed, removed_value_i);
          check_field("element_count", VALUE_W'(oldest.count), VALUE_W'(element_count_i));
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_command(opcode_i, position_i, value_i));
      end
      pending_count = expected_results.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the positional list engine testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import ple_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 500;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start_i    = 1'b0;
  logic [OPCODE_W-1:0] opcode_i   = OP_ADD_FRONT;
  logic [POS_W-1:0]    position_i = '0;
  logic [VALUE_W-1:0]  value_i    = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [VALUE_W-1:0]  removed_value_o;
  logic [COUNT_W-1:0]  element_count_o;
  int                  fail_count;
  int                  pending;

  int list_count   = 0;   // rough element count, only to shape the stimulus
  int sent         = 0;
  bit idle_enable  = 1'b1;

  positional_list_engine #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (VALUE_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .element_count_o (element_count_o)
  );

  ple_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_i          (done_o),
    .status_i        (status_o),
    .removed_value_i (removed_value_o),
    .element_count_i (element_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #200000;
    $display("positional_list_engine test failed");
    $finish;
  end

  function automatic logic [VALUE_W-1:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Mostly a legal position up to hi, sometimes anything the field holds
  function automatic logic [POS_W-1:0] pick_pos(input int hi);
    if (hi >= 1 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(1, hi));
    return POS_W'($urandom_range(0, 127));
  endfunction

  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic [VALUE_W-1:0] val);
    int p;
    while (idle_enable && $urandom_range(0, 99) < 14) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = int'(pos);
    case (op)
      OP_ADD_FRONT, OP_ADD_REAR: if (list_count < CAPACITY) list_count++;
      OP_REM_FRONT, OP_REM_REAR: if (list_count > 0) list_count--;
      OP_INS_AT: if (p >= 1 && p <= list_count + 1 && list_count < CAPACITY) list_count++;
      OP_REM_AT: if (p >= 1 && p <= list_count) list_count--;
      default: ;
    endcase
  endtask

  // Sender holds off until every transfer has its result
  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_item(input int growth);
    int sel;
    sel = $urandom_range(0, 99);
    // growth biases toward adds (positive) or removes (negative)
    sel = sel + growth;
    if (sel < 0) sel = 0;
    if (sel > 99) sel = 99;
    if ($urandom_range(0, 99) < 3) begin
      issue(OPCODE_W'($urandom_range(6, 7)), pick_pos(127), rand_word());
    end else if (sel < 22) begin
      issue(OP_REM_AT, pick_pos(list_count), rand_word());
    end else if (sel < 34) begin
      issue(OP_REM_REAR, POS_W'($urandom_range(0, 127)), rand_word());
    end else if (sel < 46) begin
      issue(OP_REM_FRONT, POS_W'($urandom_range(0, 127)), rand_word());
    end else if (sel < 64) begin
      issue(OP_INS_AT, pick_pos(list_count + 1), rand_word());
    end else if (sel < 82) begin
      issue(OP_ADD_REAR, POS_W'($urandom_range(0, 127)), rand_word());
    end else begin
      issue(OP_ADD_FRONT, POS_W'($urandom_range(0, 127)), rand_word());
    end
    sent++;
    idle_enable = !(sent >= 200 && sent < 320);
  endtask

  initial begin
    int phase;
    int len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-list cases
    issue(OP_REM_FRONT, 7'd0, '0);
    issue(OP_REM_REAR, 7'd0, '0);
    issue(OP_REM_AT, 7'd0, '1);
    issue(OP_REM_AT, 7'd1, '0);
    issue(OP_INS_AT, 7'd0, '1);
    issue(OP_INS_AT, 7'd2, '1);
    // build a short list through every add path, then take it apart again
    issue(OP_INS_AT, 7'd1, 32'h0000_0000);
    issue(OP_ADD_FRONT, 7'd127, 32'hFFFF_FFFF);
    issue(OP_ADD_REAR, 7'd0, 32'hAAAA_AAAA);
    issue(OP_INS_AT, 7'd4, 32'h5555_5555);
    issue(OP_INS_AT, 7'd2, 32'h1234_5678);
    issue(OP_REM_AT, 7'd127, '0);
    issue(OP_INS_AT, 7'd127, '1);
    issue(OPCODE_W'(6), 7'd127, '1);
    issue(OPCODE_W'(7), 7'd3, 32'hDEAD_BEEF);
    issue(OP_REM_AT, 7'd3, '0);
    issue(OP_REM_FRONT, 7'd0, '0);
    issue(OP_REM_REAR, 7'd0, '0);
    issue(OP_REM_AT, 7'd2, '0);
    issue(OP_REM_AT, 7'd1, '0);
    issue(OP_REM_AT, 7'd1, '0);
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 2);
      if (phase == 0) begin
        len = $urandom_range(10, 40);
        repeat (len) random_item(0);
      end else if (phase == 1) begin
        // fill to capacity, then knock on the full list
        while (list_count < CAPACITY) random_item(40);
        repeat ($urandom_range(3, 6)) random_item(60);
        issue(OP_INS_AT, POS_W'(CAPACITY + 1), rand_word());
        issue(OP_INS_AT, POS_W'(CAPACITY + 2), rand_word());
      end else begin
        while (list_count > 0) random_item(-40);
        repeat ($urandom_range(3, 6)) random_item(-60);
      end
      if ($urandom_range(0, 99) < 30) wait_drained();
    end

    wait_drained();
    repeat (3) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
verif/ple_checker.sv
verif/testbench.sv
